// File: rtl/ljs_pkg.sv
// Shared widths, register indexes and saturating helpers for the smoothed LJ energy core.
`default_nettype none
package ljs_pkg;

  // Distances fed to the term datapath are at most twice the 32-bit cutoff.
  localparam int DW      = 33;
  localparam int UW      = 2 * DW;
  localparam int QW      = 64;
  localparam int MUL_AW  = 96;
  localparam int MUL_BW  = 64;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 64;

  localparam logic [UW:0]   REM_INIT  = (UW+1)'(1) << 32;
  localparam logic [UW-1:0] U_SAT_MAX = UW'(1) << 32;

  localparam logic signed [QW-1:0] SAT_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [CFG_IW-1:0] {
    REG_CUTOFF       = 2'd0,
    REG_SIGMA_SIXTH  = 2'd1,
    REG_MIRROR_SHIFT = 2'd2,
    REG_ENERGY_SCALE = 2'd3
  } cfg_reg_t;

  function automatic logic signed [QW-1:0] sat_wide(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = {{64{1'b0}}, SAT_MAX};
    lo = {{64{1'b1}}, SAT_MIN};
    if (v > hi) return SAT_MAX;
    else if (v < lo) return SAT_MIN;
    else return v[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] sadd(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [127:0] s;
    s = {{64{a[QW-1]}}, a} + {{64{b[QW-1]}}, b};
    return sat_wide(s);
  endfunction

endpackage
`default_nettype wire

// File: rtl/ljs_mul.sv
// Shared multiplier: 96 x 64 bit product from six registered 32 x 32 partial products.
`default_nettype none
module ljs_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ljs_pkg::MUL_AW-1:0]  a,
  input  logic [ljs_pkg::MUL_BW-1:0]  b,
  output logic                        done,
  output logic [ljs_pkg::MUL_PW-1:0]  prod
);
  import ljs_pkg::*;

  localparam int NPP = (MUL_AW / 32) * (MUL_BW / 32);

  logic [MUL_AW-1:0] a_r;
  logic [MUL_BW-1:0] b_r;
  logic [MUL_PW-1:0] acc_r;
  logic [63:0]       pp_r;
  logic [1:0]        sh_r;
  logic              pv_r;
  logic [2:0]        step_r;
  logic              busy_r;
  logic              done_r;

  logic [1:0]        ia;
  logic              ib;
  logic [31:0]       la;
  logic [31:0]       lb;
  logic [MUL_PW-1:0] pp_sh;

  always_comb begin
    ia    = step_r[2:1];
    ib    = step_r[0];
    la    = a_r[32*ia +: 32];
    lb    = b_r[32*ib +: 32];
    pp_sh = MUL_PW'(pp_r) << {sh_r, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      pv_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        pv_r   <= 1'b0;
      end else if (busy_r) begin
        if (step_r == 3'(NPP)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
          pv_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r != 3'(NPP)) begin
        pp_r <= la * lb;
        sh_r <= ia + 2'(ib);
      end
      if (pv_r) acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// File: rtl/ljs_div.sv
// Restoring divider: one quotient bit per cycle of 2^96 divided by the squared distance.
`default_nettype none
module ljs_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ljs_pkg::UW-1:0]  divisor,
  output logic                    done,
  output logic [ljs_pkg::QW-1:0]  quot
);
  import ljs_pkg::*;

  logic [UW:0]   rem_r;
  logic [UW-1:0] dv_r;
  logic [QW-1:0] q_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [UW:0]   rem2;
  logic          ge;

  always_comb begin
    rem2 = {rem_r[UW-1:0], 1'b0};
    ge   = rem2 >= {1'b0, dv_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The remainder starts at 2^32, below any divisor that does not saturate,
  // so only the low 64 quotient bits are ever nonzero.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_INIT;
      dv_r  <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem2 - {1'b0, dv_r}) : rem2;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// File: rtl/lennard_jones_smoothed_energy_sum_core.sv
// Smoothed Lennard-Jones 12-6 energy accumulator: sequencer around a shared multiplier and divider.
// A distance at or above the cutoff is taken in the idle state; one below it computes
// two terms, each of one divide plus five multiplies on the shared units unless it saturates early.
// A last word adds output scaling on the multiplier.
// One word is in flight at a time; the finished result sits in an output register.
// Synchronous active-low reset clears the sums, the sequencer and restores the registers.
`default_nettype none
module lennard_jones_smoothed_energy_sum_core #(
  parameter int DIST_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [DIST_WIDTH-1:0]             in_distance,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ljs_pkg::QW-1:0]     out_total_energy,
  output logic signed [ljs_pkg::QW-1:0]     out_smoothing_energy,
  input  logic                              cfg_wr_en,
  input  logic [ljs_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [ljs_pkg::CFG_DW-1:0]        cfg_wdata
);
  import ljs_pkg::*;

  localparam int CW = (DIST_WIDTH > DW) ? DIST_WIDTH : DW;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_SQR  = 12'b0000_0000_0010,
    ST_DIV  = 12'b0000_0000_0100,
    ST_P1   = 12'b0000_0000_1000,
    ST_P2   = 12'b0000_0001_0000,
    ST_P3   = 12'b0000_0010_0000,
    ST_P4   = 12'b0000_0100_0000,
    ST_ACC  = 12'b0000_1000_0000,
    ST_SUM  = 12'b0001_0000_0000,
    ST_OUT1 = 12'b0010_0000_0000,
    ST_OUT2 = 12'b0100_0000_0000,
    ST_EMIT = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;

  logic [31:0]           cutoff_r;
  logic [39:0]           sigma_r;
  logic signed [QW-1:0]  mirror_r;
  logic [47:0]           scale_r;

  logic [DW-1:0]         d_r, d_nxt;
  logic [DW-1:0]         rd_r, rd_nxt;
  logic [QW-1:0]         v_r, v_nxt;
  logic [QW-1:0]         x_r, x_nxt;
  logic [79:0]           w_r, w_nxt;
  logic signed [QW-1:0]  term_r, term_nxt;
  logic                  mode_r, mode_nxt;
  logic                  last_r, last_nxt;
  logic signed [QW-1:0]  pair_r, pair_nxt;
  logic signed [QW-1:0]  smooth_r, smooth_nxt;
  logic signed [QW-1:0]  tot_r, tot_nxt;
  logic signed [QW-1:0]  res_tot_r, res_tot_nxt;
  logic signed [QW-1:0]  res_sm_r, res_sm_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [QW-1:0]  out_tot_r, out_tot_nxt;
  logic signed [QW-1:0]  out_sm_r, out_sm_nxt;

  logic [CW-1:0]         r_ext;
  logic [CW-1:0]         cut_ext;
  logic [CW:0]           rd_full;
  logic signed [QW-1:0]  sat_term;
  logic signed [127:0]   diff;

  logic                  mul_start;
  logic [MUL_AW-1:0]     mul_a;
  logic [MUL_BW-1:0]     mul_b;
  logic                  mul_done;
  logic [MUL_PW-1:0]     mul_p;
  logic                  div_start;
  logic                  div_done;
  logic [QW-1:0]         div_q;

  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] s);
    return s[QW-1] ? QW'(-s) : s;
  endfunction

  // Floor of the signed product over 2^48, saturated to 64 bits.
  function automatic logic signed [QW-1:0] scale_res(input logic neg, input logic [111:0] p);
    logic [112:0] pr;
    logic [64:0]  q;
    pr = {1'b0, p} + 113'((64'd1 << 48) - 64'd1);
    q  = pr[112:48];
    if (neg) begin
      if (q >= 65'(64'd1 << 63)) return SAT_MIN;
      else return QW'(-q);
    end else begin
      if (p[111]) return SAT_MAX;
      else return p[111:48];
    end
  endfunction

  always_comb begin
    r_ext    = CW'(in_distance);
    cut_ext  = CW'(cutoff_r);
    rd_full  = {1'b0, cut_ext} + {1'b0, cut_ext} - {1'b0, r_ext};
    sat_term = (sigma_r != '0) ? SAT_MAX : SAT_MIN;
    diff     = $signed({24'b0, mul_p[119:16]}) - $signed({64'b0, x_r});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQR: begin
        mul_a = MUL_AW'(d_r);
        mul_b = MUL_BW'(d_r);
      end
      ST_P1: begin
        mul_a = MUL_AW'(v_r);
        mul_b = v_r;
      end
      ST_P2: begin
        mul_a = MUL_AW'(x_r);
        mul_b = v_r;
      end
      ST_P3: begin
        mul_a = MUL_AW'(x_r);
        mul_b = x_r;
      end
      ST_P4: begin
        mul_a = MUL_AW'(w_r);
        mul_b = MUL_BW'(sigma_r);
      end
      ST_OUT1: begin
        mul_a = MUL_AW'(mag(tot_r));
        mul_b = MUL_BW'(scale_r);
      end
      ST_OUT2: begin
        mul_a = MUL_AW'(mag(smooth_r));
        mul_b = MUL_BW'(scale_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_start = go_r && (state_r != ST_DIV) && (state_r != ST_IDLE);
    div_start = go_r && (state_r == ST_DIV);
  end

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    d_nxt         = d_r;
    rd_nxt        = rd_r;
    v_nxt         = v_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    term_nxt      = term_r;
    mode_nxt      = mode_r;
    last_nxt      = last_r;
    pair_nxt      = pair_r;
    smooth_nxt    = smooth_r;
    tot_nxt       = tot_r;
    res_tot_nxt   = res_tot_r;
    res_sm_nxt    = res_sm_r;
    out_tot_nxt   = out_tot_r;
    out_sm_nxt    = out_sm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (r_ext < cut_ext) begin
            d_nxt     = r_ext[DW-1:0];
            rd_nxt    = rd_full[DW-1:0];
            mode_nxt  = 1'b0;
            state_nxt = ST_SQR;
            go_nxt    = 1'b1;
          end else if (in_last) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          if (mul_p[UW-1:0] <= U_SAT_MAX) begin
            term_nxt  = sat_term;
            state_nxt = ST_ACC;
          end else begin
            state_nxt = ST_DIV;
            go_nxt    = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          v_nxt     = div_q;
          state_nxt = ST_P1;
          go_nxt    = 1'b1;
        end
      end
      ST_P1, ST_P2: begin
        if (mul_done) begin
          if (mul_p[MUL_PW-1:112] != '0) begin
            term_nxt  = sat_term;
            state_nxt = ST_ACC;
          end else begin
            x_nxt     = mul_p[111:48];
            state_nxt = (state_r == ST_P1) ? ST_P2 : ST_P3;
            go_nxt    = 1'b1;
          end
        end
      end
      ST_P3: begin
        if (mul_done) begin
          w_nxt     = mul_p[127:48];
          state_nxt = ST_P4;
          go_nxt    = 1'b1;
        end
      end
      ST_P4: begin
        if (mul_done) begin
          term_nxt  = sat_wide(diff);
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!mode_r) begin
          pair_nxt  = sadd(pair_r, term_r);
          mode_nxt  = 1'b1;
          d_nxt     = rd_r;
          state_nxt = ST_SQR;
          go_nxt    = 1'b1;
        end else begin
          smooth_nxt = sadd(smooth_r, sadd(term_r, mirror_r));
          state_nxt  = last_r ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        tot_nxt   = sadd(pair_r, smooth_r);
        state_nxt = ST_OUT1;
        go_nxt    = 1'b1;
      end
      ST_OUT1: begin
        if (mul_done) begin
          res_tot_nxt = scale_res(tot_r[QW-1], mul_p[111:0]);
          state_nxt   = ST_OUT2;
          go_nxt      = 1'b1;
        end
      end
      ST_OUT2: begin
        if (mul_done) begin
          res_sm_nxt = scale_res(smooth_r[QW-1], mul_p[111:0]);
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_tot_nxt   = res_tot_r;
          out_sm_nxt    = res_sm_r;
          out_valid_nxt = 1'b1;
          pair_nxt      = '0;
          smooth_nxt    = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pair_r      <= '0;
      smooth_r    <= '0;
      cutoff_r    <= 32'd134217728;
      sigma_r     <= 40'd832226918;
      mirror_r    <= '0;
      scale_r     <= 48'd7061000000;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      pair_r      <= pair_nxt;
      smooth_r    <= smooth_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_CUTOFF:       cutoff_r <= cfg_wdata[31:0];
          REG_SIGMA_SIXTH:  sigma_r  <= cfg_wdata[39:0];
          REG_MIRROR_SHIFT: mirror_r <= cfg_wdata;
          REG_ENERGY_SCALE: scale_r  <= cfg_wdata[47:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r       <= d_nxt;
    rd_r      <= rd_nxt;
    v_r       <= v_nxt;
    x_r       <= x_nxt;
    w_r       <= w_nxt;
    term_r    <= term_nxt;
    mode_r    <= mode_nxt;
    last_r    <= last_nxt;
    tot_r     <= tot_nxt;
    res_tot_r <= res_tot_nxt;
    res_sm_r  <= res_sm_nxt;
    out_tot_r <= out_tot_nxt;
    out_sm_r  <= out_sm_nxt;
  end

  ljs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  ljs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (mul_p[UW-1:0]),
    .done    (div_done),
    .quot    (div_q)
  );

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_total_energy     = out_tot_r;
  assign out_smoothing_energy = out_sm_r;

endmodule
`default_nettype wire

// File: rtl/ljs_chk.sv
// Port-level checker for the smoothed LJ energy core, bound to the top level.
`default_nettype none
module ljs_chk #(
  parameter int DIST_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [DIST_WIDTH-1:0]         in_distance,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [ljs_pkg::QW-1:0] out_total_energy,
  input logic signed [ljs_pkg::QW-1:0] out_smoothing_energy,
  input logic                          cfg_wr_en,
  input logic [ljs_pkg::CFG_IW-1:0]    cfg_index,
  input logic [ljs_pkg::CFG_DW-1:0]    cfg_wdata
);
  import ljs_pkg::*;

  // Reset leaves no word on the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_energy)
      && $stable(out_smoothing_energy))
    else $error("result word changed while stalled");

  // Only a word marked last may produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last && !out_valid |=> !out_valid)
    else $error("result produced without a last word");

  // An accepted last word always leaves the idle state, so input closes.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after a last word");

endmodule

bind lennard_jones_smoothed_energy_sum_core ljs_chk #(.DIST_WIDTH(DIST_WIDTH)) u_ljs_chk (.*);
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the smoothed Lennard-Jones energy accumulator core.
`default_nettype none

class energy_scoreboard;
  typedef struct {
    logic signed [63:0] total;
    logic signed [63:0] smooth;
  } energy_pair_t;

  localparam logic signed [63:0] POS_LIMIT = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] NEG_LIMIT = {1'b1, {63{1'b0}}};

  logic [31:0]        cutoff;
  logic [39:0]        sigma_sixth;
  logic signed [63:0] mirror_shift;
  logic [47:0]        energy_scale;
  logic signed [63:0] pair_acc;
  logic signed [63:0] smooth_acc;
  energy_pair_t       pending_energies[$];
  int                 errors;
  int                 checked;

  function new();
    cutoff       = 32'd134217728;
    sigma_sixth  = 40'd832226918;
    mirror_shift = '0;
    energy_scale = 48'd7061000000;
    pair_acc     = '0;
    smooth_acc   = '0;
    errors       = 0;
    checked      = 0;
  endfunction

  function void write_reg(ljs_pkg::cfg_reg_t idx, logic [63:0] value);
    case (idx)
      ljs_pkg::REG_CUTOFF:       cutoff = value[31:0];
      ljs_pkg::REG_SIGMA_SIXTH:  sigma_sixth = value[39:0];
      ljs_pkg::REG_MIRROR_SHIFT: mirror_shift = value;
      ljs_pkg::REG_ENERGY_SCALE: energy_scale = value[47:0];
      default: ;
    endcase
  endfunction

  function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    if (s > 66'(POS_LIMIT)) return POS_LIMIT;
    if (s < 66'(NEG_LIMIT)) return NEG_LIMIT;
    return s[63:0];
  endfunction

  // (s6/r^6 - 1)/r^6 in Q16.48 for a raw distance d, saturating.
  function logic signed [63:0] pair_term(logic [63:0] d);
    logic [127:0] u, q, t, x, a, dlt;
    bit           ovf;
    ovf = 0;
    u = 128'(d) * 128'(d);
    if (u == 0) begin
      ovf = 1;
    end else begin
      q = (128'd1 << 96) / u;
      if (q[127:64] != 0) ovf = 1;
    end
    if (!ovf) begin
      t = (q * q) >> 48;
      if (t[127:64] != 0) ovf = 1;
      else begin
        t = (t * q) >> 48;
        if (t[127:64] != 0) ovf = 1;
      end
    end
    if (ovf) return (sigma_sixth != 0) ? POS_LIMIT : NEG_LIMIT;
    x = t;
    t = (x * x) >> 48;
    a = (t * 128'(sigma_sixth)) >> 16;
    if (a >= x) begin
      dlt = a - x;
      if (dlt > 128'(POS_LIMIT)) return POS_LIMIT;
      return dlt[63:0];
    end
    dlt = x - a;
    if (dlt >= (128'd1 << 63)) return NEG_LIMIT;
    return -$signed(dlt[63:0]);
  endfunction

  // Q16.48 sum times Q16.32 scale to Q32.32, floored, saturating.
  function logic signed [63:0] scaled(logic signed [63:0] s);
    logic [127:0] mag, p, q;
    mag = (s < 0) ? 128'(-s) : 128'(s);
    if (s == NEG_LIMIT) mag = 128'd1 << 63;
    p = mag * 128'(energy_scale);
    if (s < 0) begin
      q = (p + ((128'd1 << 48) - 1)) >> 48;
      if (q >= (128'd1 << 63)) return NEG_LIMIT;
      return -$signed(q[63:0]);
    end
    q = p >> 48;
    if (q > 128'(POS_LIMIT)) return POS_LIMIT;
    return q[63:0];
  endfunction

  function void note_distance(logic [31:0] r, bit last);
    energy_pair_t e;
    logic [63:0]  rd;
    if (r < cutoff) begin
      rd = 64'(cutoff) * 2 - 64'(r);
      pair_acc   = sat_add(pair_acc, pair_term(64'(r)));
      smooth_acc = sat_add(smooth_acc, sat_add(pair_term(rd), mirror_shift));
    end
    if (last) begin
      e.total  = scaled(sat_add(pair_acc, smooth_acc));
      e.smooth = scaled(smooth_acc);
      pending_energies.push_back(e);
      pair_acc   = '0;
      smooth_acc = '0;
    end
  endfunction

  function void check_energy(logic signed [63:0] total, logic signed [63:0] smooth);
    energy_pair_t e;
    checked++;
    if (pending_energies.size() == 0) begin
      $error("unexpected result word: total_energy %0d smoothing_energy %0d", total, smooth);
      errors++;
      return;
    end
    e = pending_energies.pop_front();
    if (total !== e.total) begin
      $error("total_energy expected %0d actual %0d", e.total, total);
      errors++;
    end
    if (smooth !== e.smooth) begin
      $error("smoothing_energy expected %0d actual %0d", e.smooth, smooth);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE = 300;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [31:0]               in_distance;
  logic                      in_last;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [63:0]        out_total_energy;
  logic signed [63:0]        out_smoothing_energy;
  logic                      cfg_wr_en;
  logic [ljs_pkg::CFG_IW-1:0] cfg_index;
  logic [ljs_pkg::CFG_DW-1:0] cfg_wdata;

  energy_scoreboard sb;
  bit quiet;
  bit hold_req;
  int hold_left;
  int stall_left;
  int idle_cycles;
  int items_sent;

  lennard_jones_smoothed_energy_sum_core #(.DIST_WIDTH(32)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_distance(in_distance), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_total_energy(out_total_energy),
    .out_smoothing_energy(out_smoothing_energy),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Result side: checking, random stalls, the long hold-off and the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_energy(out_total_energy, out_smoothing_energy);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_distance(logic [31:0] r, bit last);
    in_valid    <= 1'b1;
    in_distance <= r;
    in_last     <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_distance(r, last);
    items_sent++;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_energies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(ljs_pkg::cfg_reg_t idx, logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] c, logic [39:0] s6, logic [63:0] m, logic [47:0] e);
    write_reg(ljs_pkg::REG_CUTOFF, 64'(c));
    write_reg(ljs_pkg::REG_SIGMA_SIXTH, 64'(s6));
    write_reg(ljs_pkg::REG_MIRROR_SHIFT, m);
    write_reg(ljs_pkg::REG_ENERGY_SCALE, 64'(e));
  endtask

  function automatic logic [31:0] pick_distance();
    logic [31:0] c;
    c = sb.cutoff;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 65535);
      2: return (c > 16) ? $urandom_range(c - 16, c) : $urandom_range(0, 16);
      default: return (c > 1) ? $urandom_range(0, c - 1) : $urandom;
    endcase
  endfunction

  // Mostly well-formed sets of a few distances closed by a last word.
  task automatic random_sets(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        send_distance(pick_distance(), k == len - 1);
        n++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_distance = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet = 0;
    hold_req = 0;
    hold_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings: zero and tiny distances, one, the cutoff edges.
    send_distance(32'd0, 1'b1);
    send_distance(32'd1, 1'b0);
    send_distance(32'd1024, 1'b0);
    send_distance(32'h0100_0000, 1'b1);
    send_distance(32'hFFFF_FFFF, 1'b1);
    send_distance(sb.cutoff, 1'b0);
    send_distance(sb.cutoff - 1, 1'b1);
    send_distance(32'h0080_0000, 1'b0);
    send_distance(32'h0200_0000, 1'b0);
    send_distance(32'h0400_0000, 1'b1);
    send_distance(32'hAAAA_AAAA, 1'b0);
    send_distance(32'h5555_5555, 1'b1);
    hold_req = 1;
    random_sets(60);
    wait_idle();

    // Extremes of every register.
    write_all(32'hFFFF_FFFF, 40'd0, {1'b1, 63'd0}, 48'hFFFF_FFFF_FFFF);
    send_distance(32'd0, 1'b0);
    send_distance(32'hFFFF_FFFE, 1'b0);
    send_distance(32'h0100_0000, 1'b1);
    random_sets(50);
    wait_idle();

    write_all(32'd1, 40'hFF_FFFF_FFFF, {1'b0, {63{1'b1}}}, 48'd0);
    send_distance(32'd0, 1'b1);
    send_distance(32'd1, 1'b1);
    random_sets(30);
    wait_idle();

    // With a zero cutoff every distance is ignored.
    write_reg(ljs_pkg::REG_CUTOFF, 64'd0);
    send_distance(32'd0, 1'b0);
    send_distance($urandom, 1'b1);
    random_sets(20);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      write_all($urandom_range(32'h0080_0000, 32'h1000_0000),
                {8'($urandom_range(0, 255)), $urandom},
                (p[0]) ? {$urandom, $urandom} : 64'($signed($urandom_range(0, 1 << 20)) - 524288),
                {16'($urandom_range(0, 65535)), $urandom});
      random_sets(60);
      wait_idle();
    end

    // Back to reset values; the closing stretch runs without idling.
    write_all(32'd134217728, 40'd832226918, 64'd0, 48'd7061000000);
    quiet = 1;
    random_sets(90);
    in_valid <= 1'b0;
    while (sb.pending_energies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d distance words over nine register settings, including extremes,",
             items_sent);
    $display("zero cutoff and a long result hold-off; %0d result words checked.", sb.checked);
    if (sb.errors == 0 && sb.pending_energies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
